// ===== sv/sgml_tag_delimiter_scanner_macros.svh =====
// Assertion macros used by the scanner's checker file.
// No dependencies; include by bare file name.
`ifndef SGML_TAG_DELIMITER_SCANNER_MACROS_SVH
`define SGML_TAG_DELIMITER_SCANNER_MACROS_SVH

// Same-cycle implication, quiet while reset is low.
`define STDS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, quiet while reset is low.
`define STDS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/stds_pkg.sv =====
// Shared types, codes and character constants for the SGML tag delimiter scanner.
// No dependencies; used by the top level and its checker.
`timescale 1ns / 1ps
`default_nettype none

package stds_pkg;

    localparam int OFFSET_WIDTH_DEF      = 32;
    localparam int MAX_BRACKET_DEPTH_DEF = 255;

    // Result kinds
    localparam logic [1:0] KIND_TAG    = 2'd0;
    localparam logic [1:0] KIND_CLEAN  = 2'd1;
    localparam logic [1:0] KIND_BROKEN = 2'd2;

    // Markup characters
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_BANG   = 8'h21;
    localparam logic [7:0] CH_DASH   = 8'h2D;

    typedef enum logic [1:0] {
        MODE_OUT,
        MODE_TAG,
        MODE_DECL
    } t_mode;

    typedef enum logic [2:0] {
        PH_NONE,
        PH_LT,
        PH_LT_BANG,
        PH_LT_BANG_DASH,
        PH_SKIP_WS,
        PH_COMMENT
    } t_phase;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       record_end;
    } t_in;

    typedef struct packed {
        logic [1:0]  event_kind;
        logic [31:0] tag_start;
        logic [31:0] tag_end;
        logic        last_of_run;
    } t_out;

    // Space, TAB, LF, VT, FF, CR
    function automatic logic is_white(input logic [7:0] c);
        return c inside {8'h20, [8'h09:8'h0D]};
    endfunction

endpackage

`default_nettype wire

// ===== sv/sgml_tag_delimiter_scanner.sv =====
// SGML tag delimiter scanner: top level with scan state and result queue.
// Depends on stds_pkg.
`timescale 1ns / 1ps
`default_nettype none

// The scanner takes one byte per clock and reports, for each tag closed by
// '>', the offset of the tag's first non-space byte after '<' and the offset
// of the '>'. Declarations "<!...>" are skipped with nested '[' ']' and
// comments "<!-- ... -->" are skipped to the first "-->". The byte flagged
// record_end also yields a status result (clean, or ended inside a tag,
// a declaration or a '<' opener) and returns all scan state but the
// accept_empty_tags register to reset. Each byte is decoded combinationally
// against the scan-state registers, and its zero, one or two results are
// written into a four-entry result queue that drains one transaction per
// clock while i_stall is low. Throughput is one byte per clock as long as
// the result side keeps up; o_stall rises when the queue holds three or
// more results. A byte with two results (a tag close on the last byte)
// fills two queue entries; o_data shows the registered head. The cfg
// channel, which is always ready, writes the accept_empty_tags register.
module sgml_tag_delimiter_scanner #(
    parameter int OFFSET_WIDTH      = stds_pkg::OFFSET_WIDTH_DEF,
    parameter int MAX_BRACKET_DEPTH = stds_pkg::MAX_BRACKET_DEPTH_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    // configuration write
    input  wire logic          i_cfg_valid,
    output logic               o_cfg_ready,
    input  wire logic          i_cfg_data,
    // byte input
    input  wire logic          i_valid,
    output logic               o_stall,
    input  wire stds_pkg::t_in i_data,
    // result output
    output logic               o_valid,
    input  wire logic          i_stall,
    output stds_pkg::t_out     o_data
);
    import stds_pkg::*;

    localparam int DEPTH_W = $clog2(MAX_BRACKET_DEPTH + 1);
    localparam int EXT_W   = (OFFSET_WIDTH > 32) ? OFFSET_WIDTH : 32;
    localparam int Q_DEPTH = 4;
    localparam int QA_W    = $clog2(Q_DEPTH);
    localparam int QC_W    = $clog2(Q_DEPTH + 1);

    // Scan state
    logic                    r_accept_empty;
    t_mode                   r_mode,  n_mode;
    t_phase                  r_phase, n_phase;
    logic [1:0]              r_cprog, n_cprog;
    logic [DEPTH_W-1:0]      r_depth, n_depth;
    logic [OFFSET_WIDTH-1:0] r_pos,   n_pos;
    logic [OFFSET_WIDTH-1:0] r_pend,  n_pend;

    // Result queue
    t_out                    r_q [Q_DEPTH];
    logic [QA_W-1:0]         r_wp, r_rp;
    logic [QC_W-1:0]         r_cnt;

    logic                    in_acc;
    logic                    out_pop;
    logic                    do_plain;
    logic                    do_begin;
    logic                    tag_hit;
    logic                    bad_end;
    logic [OFFSET_WIDTH-1:0] tag_pend;
    logic [EXT_W-1:0]        pend_ext;
    logic [EXT_W-1:0]        pos_ext;
    logic [1:0]              n_push;
    t_out                    res0, res1;
    logic [7:0]              c;

    // Config channel never back-pressures
    assign o_cfg_ready = 1'b1;

    // Hold off input once the queue might not take two more results
    assign o_stall = (r_cnt >= QC_W'(Q_DEPTH - 1));
    assign in_acc  = i_valid && !o_stall;

    assign o_valid = (r_cnt != '0);
    assign o_data  = r_q[r_rp];
    assign out_pop = o_valid && !i_stall;

    assign c = i_data.data_byte;

    // Byte decode: lookahead phase first, then ordinary byte handling
    always_comb begin
        n_mode   = r_mode;
        n_phase  = r_phase;
        n_cprog  = r_cprog;
        n_depth  = r_depth;
        n_pend   = r_pend;
        n_pos    = r_pos + OFFSET_WIDTH'(1);
        do_plain = 1'b0;
        do_begin = 1'b0;
        tag_hit  = 1'b0;

        case (r_phase)
            PH_COMMENT: begin
                // look for the first "-->"
                if (c == CH_DASH) begin
                    if (r_cprog != 2'd2) begin
                        n_cprog = r_cprog + 2'd1;
                    end
                end else if (c == CH_GT && r_cprog == 2'd2) begin
                    n_cprog = 2'd0;
                    n_phase = PH_NONE;
                end else begin
                    n_cprog = 2'd0;
                end
            end
            PH_LT: begin
                if (c == CH_BANG) begin
                    n_phase = PH_LT_BANG;
                end else if (r_mode == MODE_OUT) begin
                    do_begin = 1'b1;
                end else begin
                    // '<' inside markup is dropped; treat this byte plainly
                    n_phase  = PH_NONE;
                    do_plain = 1'b1;
                end
            end
            PH_LT_BANG: begin
                if (c == CH_DASH) begin
                    n_phase = PH_LT_BANG_DASH;
                end else begin
                    n_mode   = MODE_DECL;
                    n_phase  = PH_NONE;
                    do_plain = 1'b1;
                end
            end
            PH_LT_BANG_DASH: begin
                if (c == CH_DASH) begin
                    n_phase = PH_COMMENT;
                    n_cprog = 2'd0;
                end else begin
                    n_mode   = MODE_DECL;
                    n_phase  = PH_NONE;
                    do_plain = 1'b1;
                end
            end
            PH_SKIP_WS: begin
                do_begin = 1'b1;
            end
            default: begin
                n_phase  = PH_NONE;
                do_plain = 1'b1;
            end
        endcase

        // Tag start: skip white space, then latch the start offset
        if (do_begin) begin
            if (is_white(c)) begin
                n_phase = PH_SKIP_WS;
            end else begin
                n_phase = PH_NONE;
                n_pend  = r_pos;
                n_mode  = MODE_TAG;
                if (r_accept_empty && c == CH_GT) begin
                    do_plain = 1'b1;
                end
            end
        end

        if (do_plain) begin
            case (c)
                CH_LBRACK: begin
                    if (n_mode == MODE_DECL && n_depth < DEPTH_W'(MAX_BRACKET_DEPTH)) begin
                        n_depth = n_depth + DEPTH_W'(1);
                    end
                end
                CH_RBRACK: begin
                    if (n_mode == MODE_DECL && n_depth != '0) begin
                        n_depth = n_depth - DEPTH_W'(1);
                    end
                end
                CH_GT: begin
                    if (n_mode == MODE_DECL && n_depth == '0) begin
                        n_mode = MODE_OUT;
                    end else if (n_mode == MODE_TAG) begin
                        n_mode  = MODE_OUT;
                        tag_hit = 1'b1;
                    end
                end
                CH_LT: begin
                    n_phase = PH_LT;
                end
                default: begin
                end
            endcase
        end

        tag_pend = n_pend;
        bad_end  = (n_mode != MODE_OUT) || (n_phase inside
                   {PH_LT, PH_LT_BANG, PH_LT_BANG_DASH, PH_SKIP_WS});

        // Record end: return everything to reset
        if (i_data.record_end) begin
            n_mode  = MODE_OUT;
            n_phase = PH_NONE;
            n_cprog = 2'd0;
            n_depth = '0;
            n_pos   = '0;
            n_pend  = '0;
        end
    end

    assign pend_ext = EXT_W'(tag_pend);
    assign pos_ext  = EXT_W'(r_pos);

    // Assemble up to two results: tag close first, then record status
    always_comb begin
        t_out tag_res;
        t_out st_res;
        tag_res.event_kind  = KIND_TAG;
        tag_res.tag_start   = pend_ext[31:0];
        tag_res.tag_end     = pos_ext[31:0];
        tag_res.last_of_run = !i_data.record_end;
        st_res.event_kind   = bad_end ? KIND_BROKEN : KIND_CLEAN;
        st_res.tag_start    = 32'd0;
        st_res.tag_end      = 32'd0;
        st_res.last_of_run  = 1'b1;
        res0   = tag_hit ? tag_res : st_res;
        res1   = st_res;
        n_push = {1'b0, tag_hit} + {1'b0, i_data.record_end};
    end

    // Control and scan state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_accept_empty <= 1'b0;
            r_mode         <= MODE_OUT;
            r_phase        <= PH_NONE;
            r_cprog        <= 2'd0;
            r_depth        <= '0;
            r_pos          <= '0;
            r_pend         <= '0;
            r_wp           <= '0;
            r_rp           <= '0;
            r_cnt          <= '0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_accept_empty <= i_cfg_data;
            end
            if (in_acc) begin
                r_mode  <= n_mode;
                r_phase <= n_phase;
                r_cprog <= n_cprog;
                r_depth <= n_depth;
                r_pos   <= n_pos;
                r_pend  <= n_pend;
                r_wp    <= r_wp + QA_W'(n_push);
            end
            if (out_pop) begin
                r_rp <= r_rp + QA_W'(1);
            end
            r_cnt <= r_cnt + QC_W'(in_acc ? n_push : 2'd0) - QC_W'(out_pop);
        end
    end

    // Queue payload, no reset
    always_ff @(posedge i_clk) begin
        if (in_acc && n_push != 2'd0) begin
            r_q[r_wp] <= res0;
        end
        if (in_acc && n_push == 2'd2) begin
            r_q[r_wp + QA_W'(1)] <= res1;
        end
    end

endmodule

`default_nettype wire

// ===== sv/stds_chk.sv =====
// Port-level checker for the SGML tag delimiter scanner, bound to the top level.
// Depends on stds_pkg and sgml_tag_delimiter_scanner_macros.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "sgml_tag_delimiter_scanner_macros.svh"

module stds_chk (
    input wire logic           i_clk,
    input wire logic           i_rst_n,
    input wire logic           o_valid,
    input wire logic           i_stall,
    input wire stds_pkg::t_out o_data
);
    import stds_pkg::*;

    // Stalled result holds
    `STDS_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_data), "stalled result changed")

    // Only three result kinds exist
    `STDS_ASSERT_NOW(a_kind_legal, i_clk, i_rst_n, o_valid, o_data.event_kind <= KIND_BROKEN, "illegal result kind")

    // A status result always closes its byte's run and carries no offsets
    `STDS_ASSERT_NOW(a_status_shape, i_clk, i_rst_n, o_valid && o_data.event_kind != KIND_TAG, o_data.last_of_run && o_data.tag_start == 32'd0 && o_data.tag_end == 32'd0, "bad status result")

    // A tag close that is not last of its run is followed by its status
    `STDS_ASSERT_NEXT(a_status_follows, i_clk, i_rst_n, o_valid && !i_stall && o_data.event_kind == KIND_TAG && !o_data.last_of_run, o_valid && o_data.event_kind != KIND_TAG, "status missing after tag")

endmodule

bind sgml_tag_delimiter_scanner stds_chk u_stds_chk (.*);

`default_nettype wire
